[rtl/core/pcve_pkg.sv]
package pcve_pkg;

  // Store geometry and field widths
  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;
  localparam int unsigned ACC_W        = PROD_W + 1;
  localparam int unsigned LEN_W        = 40;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_FIND     = 2'd2,
    OP_PATH     = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_NONE = 2'd3
  } status_e;

endpackage

[rtl/core/pcve_req_if.sv]
interface pcve_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [pcve_pkg::OP_W-1:0]              operation;
  logic signed [pcve_pkg::COORD_W-1:0]    coord_x;
  logic signed [pcve_pkg::COORD_W-1:0]    coord_y;
  logic [pcve_pkg::IDX_W-1:0]             start_index;
  logic [pcve_pkg::IDX_W-1:0]             end_index;
  logic                                   count_self;
  logic                                   clockwise;
  logic                                   only_convex;

  modport source (
    output valid, operation, coord_x, coord_y, start_index, end_index,
           count_self, clockwise, only_convex,
    input  ready
  );

  modport sink (
    input  valid, operation, coord_x, coord_y, start_index, end_index,
           count_self, clockwise, only_convex,
    output ready
  );
endinterface

[rtl/core/pcve_rsp_if.sv]
interface pcve_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pcve_pkg::STATUS_W-1:0]   status;
  logic [pcve_pkg::IDX_W-1:0]      found_index;
  logic [pcve_pkg::LEN_W-1:0]      path_length_sq;
  logic [pcve_pkg::CNT_W-1:0]      vertex_count;

  modport source (
    output valid, status, found_index, path_length_sq, vertex_count,
    input  ready
  );

  modport sink (
    input  valid, status, found_index, path_length_sq, vertex_count,
    output ready
  );
endinterface

[rtl/core/polygon_convex_vertex_engine_core.sv]
// Channel | Dir | Carries                                              | Handshake
// req_i   | in  | operation, coord_x/y, start/end_index, flags         | valid/ready
// rsp_o   | out | status, found_index, path_length_sq, vertex_count    | valid/ready
//
// Add, and classify with three or fewer vertices, go straight to the finish state; a longer
// classify slides a three-vertex window over every vertex; find and path walk the convex
// flags circularly.
// One transaction is in flight at a time; ready is high only while idle.
// Reset (async, active low) clears the vertex count, convex flags and handshake state.
// A stalled response holds in the output register; the next request is still taken.
module polygon_convex_vertex_engine_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  pcve_req_if.sink   req_i,
  pcve_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W   = pcve_pkg::IDX_W;
  localparam int unsigned CNT_W   = pcve_pkg::CNT_W;
  localparam int unsigned COORD_W = pcve_pkg::COORD_W;
  localparam int unsigned DIFF_W  = pcve_pkg::DIFF_W;
  localparam int unsigned PROD_W  = pcve_pkg::PROD_W;
  localparam int unsigned ACC_W   = pcve_pkg::ACC_W;
  localparam int unsigned LEN_W   = pcve_pkg::LEN_W;
  localparam int unsigned MAX_V   = pcve_pkg::MAX_VERTICES;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_CL_RD  = 11'b000_0000_0010,
    S_CL_SH  = 11'b000_0000_0100,
    S_CL_MUL = 11'b000_0000_1000,
    S_WALK   = 11'b000_0001_0000,
    S_PA_RD  = 11'b000_0010_0000,
    S_PA_M0  = 11'b000_0100_0000,
    S_PA_CHK = 11'b000_1000_0000,
    S_PA_LD  = 11'b001_0000_0000,
    S_PA_MUL = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_e;

  // Step one place around the polygon in the walk direction, with wrap.
  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] pos,
                                                input logic [CNT_W-1:0] n,
                                                input logic             cw);
    logic [CNT_W-1:0] nm1;
    nm1 = n - CNT_W'(1);
    if (cw) begin
      step_idx = ({1'b0, pos} == nm1) ? '0 : pos + IDX_W'(1);
    end else begin
      step_idx = (pos == '0) ? nm1[IDX_W-1:0] : pos - IDX_W'(1);
    end
  endfunction

  // Control state
  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [MAX_V-1:0]       flags_q, flags_d;
  logic                   rsp_valid_q, rsp_valid_d;

  // Sequencer working registers
  logic [IDX_W-1:0]       pos_q, pos_d;      // memory read address / walk position
  logic [IDX_W-1:0]       mi_q, mi_d;        // vertex under classify, or path cursor
  logic [IDX_W-1:0]       e_q, e_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;      // candidates checked in the walk
  logic [CNT_W-1:0]       steps_q, steps_d;  // path segments taken
  logic [1:0]             fill_q, fill_d;
  logic [2:0]             mstep_q, mstep_d;
  logic                   cw_q, cw_d;
  logic                   path_q, path_d;

  // Vertex window: previous, current, next
  logic signed [COORD_W-1:0] px_q, px_d, py_q, py_d;
  logic signed [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [COORD_W-1:0] nx_q, nx_d, ny_q, ny_d;

  // Shared multiplier and accumulators
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc0_q, acc0_d, acc1_q, acc1_d;
  logic [LEN_W-1:0]          len_q, len_d;
  pcve_pkg::status_e         st_q, st_d;
  logic [IDX_W-1:0]          found_q, found_d;

  // Output register payload
  pcve_pkg::status_e         rsp_st_q, rsp_st_d;
  logic [IDX_W-1:0]          rsp_found_q, rsp_found_d;
  logic [LEN_W-1:0]          rsp_len_q, rsp_len_d;
  logic [CNT_W-1:0]          rsp_cnt_q, rsp_cnt_d;

  // Vertex memory, one entry holds {x, y}
  logic [2*COORD_W-1:0]      vmem [MAX_V];
  logic [2*COORD_W-1:0]      rd_q;
  logic                      mem_we;
  logic [2*COORD_W-1:0]      mem_wdata;

  logic req_fire;
  logic signed [DIFF_W-1:0]  ax, ay, bx, by;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   dot;
  logic                      convex;
  logic [LEN_W:0]            len_sum;
  logic [CNT_W-1:0]          n_m1;
  logic [IDX_W-1:0]          vi_last;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign n_m1 = count_q - CNT_W'(1);
  assign vi_last = n_m1[IDX_W-1:0];

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_st_q;
  assign rsp_o.found_index    = rsp_found_q;
  assign rsp_o.path_length_sq = rsp_len_q;
  assign rsp_o.vertex_count   = rsp_cnt_q;

  // Edge vectors from the current vertex to its neighbours
  assign ax = {px_q[COORD_W-1], px_q} - {cx_q[COORD_W-1], cx_q};
  assign ay = {py_q[COORD_W-1], py_q} - {cy_q[COORD_W-1], cy_q};
  assign bx = {nx_q[COORD_W-1], nx_q} - {cx_q[COORD_W-1], cx_q};
  assign by = {ny_q[COORD_W-1], ny_q} - {cy_q[COORD_W-1], cy_q};

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = by;
    mul_b = by;
    if (path_q) begin
      if (mstep_q == 3'd0) begin
        mul_a = bx;
        mul_b = bx;
      end
    end else begin
      case (mstep_q)
        3'd0:    begin mul_a = ay; mul_b = bx; end
        3'd1:    begin mul_a = ax; mul_b = by; end
        3'd2:    begin mul_a = ax; mul_b = bx; end
        default: begin mul_a = ay; mul_b = by; end
      endcase
    end
  end

  assign prod_ext = {prod_q[PROD_W-1], prod_q};
  assign dot      = acc1_q + prod_ext;
  // Positive turn, or a straight line with both neighbours on the same side
  assign convex   = (!acc0_q[ACC_W-1] && (acc0_q != '0)) ||
                    ((acc0_q == '0) && !dot[ACC_W-1] && (dot != '0));
  assign len_sum  = {1'b0, len_q} + (LEN_W + 1)'(acc0_q[PROD_W-1:0]);

  assign mem_wdata = {req_i.coord_x, req_i.coord_y};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    flags_d     = flags_q;
    rsp_valid_d = rsp_valid_q;
    pos_d       = pos_q;
    mi_d        = mi_q;
    e_d         = e_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    fill_d      = fill_q;
    mstep_d     = mstep_q;
    cw_d        = cw_q;
    path_d      = path_q;
    px_d        = px_q;
    py_d        = py_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    prod_d      = PROD_W'(mul_a) * PROD_W'(mul_b);
    acc0_d      = acc0_q;
    acc1_d      = acc1_q;
    len_d       = len_q;
    st_d        = st_q;
    found_d     = found_q;
    rsp_st_d    = rsp_st_q;
    rsp_found_d = rsp_found_q;
    rsp_len_d   = rsp_len_q;
    rsp_cnt_d   = rsp_cnt_q;
    mem_we      = 1'b0;

    // Drop the response once taken; a fresh load below wins.
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          st_d    = pcve_pkg::ST_OK;
          found_d = '0;
          len_d   = '0;
          cw_d    = req_i.clockwise;
          e_d     = req_i.end_index;
          state_d = S_FIN;
          unique case (pcve_pkg::op_e'(req_i.operation))
            pcve_pkg::OP_ADD: begin
              if (count_q >= CNT_W'(MAX_V)) begin
                st_d = pcve_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            pcve_pkg::OP_CLASSIFY: begin
              flags_d = '0;
              path_d  = 1'b0;
              if (count_q == CNT_W'(3)) begin
                flags_d[2:0] = 3'b111;
              end else if (count_q > CNT_W'(3)) begin
                pos_d   = vi_last;
                fill_d  = '0;
                mi_d    = '0;
                state_d = S_CL_RD;
              end
            end
            pcve_pkg::OP_FIND: begin
              if ({1'b0, req_i.start_index} >= count_q) begin
                st_d = pcve_pkg::ST_BAD;
              end else begin
                path_d  = 1'b0;
                cnt_d   = '0;
                pos_d   = req_i.count_self ? req_i.start_index :
                          step_idx(req_i.start_index, count_q, req_i.clockwise);
                state_d = S_WALK;
              end
            end
            pcve_pkg::OP_PATH: begin
              if (({1'b0, req_i.start_index} >= count_q) ||
                  ({1'b0, req_i.end_index} >= count_q)) begin
                st_d = pcve_pkg::ST_BAD;
              end else if (req_i.only_convex &&
                           (!flags_q[req_i.start_index] ||
                            !flags_q[req_i.end_index])) begin
                st_d = pcve_pkg::ST_BAD;
              end else begin
                path_d  = 1'b1;
                pos_d   = req_i.start_index;
                mi_d    = req_i.start_index;
                steps_d = '0;
                state_d = S_PA_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // Classify: slide a three-vertex window around the polygon
      S_CL_RD: begin
        state_d = S_CL_SH;
      end
      S_CL_SH: begin
        px_d  = cx_q;
        py_d  = cy_q;
        cx_d  = nx_q;
        cy_d  = ny_q;
        nx_d  = rd_q[2*COORD_W-1:COORD_W];
        ny_d  = rd_q[COORD_W-1:0];
        pos_d = step_idx(pos_q, count_q, 1'b1);
        if (fill_q == 2'd2) begin
          mstep_d = '0;
          state_d = S_CL_MUL;
        end else begin
          fill_d  = fill_q + 2'd1;
          state_d = S_CL_RD;
        end
      end
      S_CL_MUL: begin
        mstep_d = mstep_q + 3'd1;
        case (mstep_q)
          3'd1: acc0_d = prod_ext;
          3'd2: acc0_d = acc0_q - prod_ext;
          3'd3: acc1_d = prod_ext;
          3'd4: begin
            flags_d[mi_q] = convex;
            if (mi_q == vi_last) begin
              state_d = S_FIN;
            end else begin
              mi_d    = mi_q + IDX_W'(1);
              state_d = S_CL_RD;
            end
          end
          default: ;
        endcase
      end

      // Circular search for the next convex vertex
      S_WALK: begin
        if (flags_q[pos_q]) begin
          if (path_q) begin
            mi_d    = pos_q;
            state_d = S_PA_LD;
          end else begin
            found_d = pos_q;
            state_d = S_FIN;
          end
        end else if ({1'b0, cnt_q} == n_m1) begin
          st_d    = pcve_pkg::ST_NONE;
          len_d   = '0;
          state_d = S_FIN;
        end else begin
          pos_d = step_idx(pos_q, count_q, cw_q);
          cnt_d = cnt_q + IDX_W'(1);
        end
      end

      // Path: load the start vertex, then hop from convex vertex to convex vertex
      S_PA_RD: begin
        state_d = S_PA_M0;
      end
      S_PA_M0: begin
        cx_d    = rd_q[2*COORD_W-1:COORD_W];
        cy_d    = rd_q[COORD_W-1:0];
        state_d = S_PA_CHK;
      end
      S_PA_CHK: begin
        if (mi_q == e_q) begin
          state_d = S_FIN;
        end else if (steps_q >= count_q) begin
          st_d    = pcve_pkg::ST_NONE;
          len_d   = '0;
          state_d = S_FIN;
        end else begin
          pos_d   = step_idx(mi_q, count_q, cw_q);
          cnt_d   = '0;
          state_d = S_WALK;
        end
      end
      S_PA_LD: begin
        nx_d    = rd_q[2*COORD_W-1:COORD_W];
        ny_d    = rd_q[COORD_W-1:0];
        mstep_d = '0;
        state_d = S_PA_MUL;
      end
      S_PA_MUL: begin
        mstep_d = mstep_q + 3'd1;
        case (mstep_q)
          3'd1: acc0_d = prod_ext;
          3'd2: acc0_d = acc0_q + prod_ext;
          3'd3: begin
            // Saturate the running length at full scale
            len_d   = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
            cx_d    = nx_q;
            cy_d    = ny_q;
            steps_d = steps_q + CNT_W'(1);
            state_d = S_PA_CHK;
          end
          default: ;
        endcase
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_st_d    = st_q;
          rsp_found_d = found_q;
          rsp_len_d   = len_q;
          rsp_cnt_d   = count_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      flags_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    mi_q        <= mi_d;
    e_q         <= e_d;
    cnt_q       <= cnt_d;
    steps_q     <= steps_d;
    fill_q      <= fill_d;
    mstep_q     <= mstep_d;
    cw_q        <= cw_d;
    path_q      <= path_d;
    px_q        <= px_d;
    py_q        <= py_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    nx_q        <= nx_d;
    ny_q        <= ny_d;
    prod_q      <= prod_d;
    acc0_q      <= acc0_d;
    acc1_q      <= acc1_d;
    len_q       <= len_d;
    st_q        <= st_d;
    found_q     <= found_d;
    rsp_st_q    <= rsp_st_d;
    rsp_found_q <= rsp_found_d;
    rsp_len_q   <= rsp_len_d;
    rsp_cnt_q   <= rsp_cnt_d;
  end

  // Vertex store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem[count_q[IDX_W-1:0]] <= mem_wdata;
    end
    rd_q <= vmem[pos_q];
  end

endmodule
